[rtl/ook_remote_switch_transmitter_assert.svh]
// Assertion macros for the transmitter RTL.
`ifndef OOK_REMOTE_SWITCH_TRANSMITTER_ASSERT_SVH
`define OOK_REMOTE_SWITCH_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ORST_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orst same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ORST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("orst next-cycle check failed");

`endif

[rtl/orst_pkg.sv]
package orst_pkg;

  localparam int SENDER_W = 26;
  localparam int UNIT_W   = 4;
  localparam int TICK_W   = 16;
  localparam int REP_W    = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SYNC1  = 4'd1,
    PH_LATCH1 = 4'd2,
    PH_SYNC2  = 4'd3,
    PH_LATCH2 = 4'd4,
    PH_DHI    = 4'd5,
    PH_DLO    = 4'd6,
    PH_CLOSE  = 4'd7,
    PH_GAP    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    REG_PULSE_HIGH   = 3'd0,
    REG_LONG_LOW     = 3'd1,
    REG_SHORT_LOW    = 3'd2,
    REG_SYNC_HIGH    = 3'd3,
    REG_FIRST_LATCH  = 3'd4,
    REG_SECOND_LATCH = 3'd5,
    REG_REPEAT       = 3'd6,
    REG_GAP          = 3'd7
  } reg_idx_t;

  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] pulse_high;
    logic [TICK_W-1:0] long_low;
    logic [TICK_W-1:0] short_low;
    logic [TICK_W-1:0] sync_high;
    logic [TICK_W-1:0] first_latch;
    logic [TICK_W-1:0] second_latch;
    logic [REP_W-1:0]  repeat_count;
    logic [TICK_W-1:0] gap;
  } cfg_t;

  typedef struct packed {
    logic              level;
    logic [TICK_W-1:0] ticks;
  } seg_t;

  typedef struct packed {
    logic pin;
    logic busy;
    logic done;
  } res_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic pending;
  } back_stat_t;

endpackage

[rtl/orst_queue.sv]
module orst_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  // two-entry queue
  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= din;
  end
endmodule

[rtl/orst_regs.sv]
module orst_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [orst_pkg::ADDR_W-1:0]   paddr,
  input  logic [orst_pkg::DATA_W-1:0]   pwdata,
  output logic [orst_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output orst_pkg::cfg_t                cfg
);
  import orst_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_high   <= 16'd310;
      cfg.long_low     <= 16'd1340;
      cfg.short_low    <= 16'd310;
      cfg.sync_high    <= 16'd275;
      cfg.first_latch  <= 16'd9900;
      cfg.second_latch <= 16'd2675;
      cfg.repeat_count <= 4'd5;
      cfg.gap          <= 16'd10000;
    end else if (wr) begin
      unique case (idx)
        REG_PULSE_HIGH:   cfg.pulse_high   <= pwdata[TICK_W-1:0];
        REG_LONG_LOW:     cfg.long_low     <= pwdata[TICK_W-1:0];
        REG_SHORT_LOW:    cfg.short_low    <= pwdata[TICK_W-1:0];
        REG_SYNC_HIGH:    cfg.sync_high    <= pwdata[TICK_W-1:0];
        REG_FIRST_LATCH:  cfg.first_latch  <= pwdata[TICK_W-1:0];
        REG_SECOND_LATCH: cfg.second_latch <= pwdata[TICK_W-1:0];
        REG_REPEAT:       cfg.repeat_count <= pwdata[REP_W-1:0];
        REG_GAP:          cfg.gap          <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PULSE_HIGH:   prdata = DATA_W'(cfg.pulse_high);
      REG_LONG_LOW:     prdata = DATA_W'(cfg.long_low);
      REG_SHORT_LOW:    prdata = DATA_W'(cfg.short_low);
      REG_SYNC_HIGH:    prdata = DATA_W'(cfg.sync_high);
      REG_FIRST_LATCH:  prdata = DATA_W'(cfg.first_latch);
      REG_SECOND_LATCH: prdata = DATA_W'(cfg.second_latch);
      REG_REPEAT:       prdata = DATA_W'(cfg.repeat_count);
      REG_GAP:          prdata = DATA_W'(cfg.gap);
      default:          prdata = '0;
    endcase
  end
endmodule

[rtl/orst_front.sv]
module orst_front #(
  parameter int ID_BITS   = 26,
  parameter int UNIT_BITS = 4,
  parameter int FW        = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type,
  input  logic [orst_pkg::SENDER_W-1:0] sender_id,
  input  logic [orst_pkg::UNIT_W-1:0]   unit_code,
  input  logic                          switch_on,
  output logic                          cmd_valid,
  output logic                          cmd_start,
  output logic [FW-1:0]                 cmd_frame,
  input  logic                          cmd_pop
);
  import orst_pkg::*;

  localparam int IdExt   = (ID_BITS > SENDER_W) ? ID_BITS : SENDER_W;
  localparam int UnitExt = (UNIT_BITS > UNIT_W) ? UNIT_BITS : UNIT_W;

  logic [IdExt-1:0]   id_ext;
  logic [UnitExt-1:0] unit_ext;
  logic [FW-1:0]      frame;
  logic               is_start;
  logic               cmd_empty;

  // frame word, MSB first on air: id, group (always zero), on/off, unit
  assign id_ext   = IdExt'(sender_id);
  assign unit_ext = UnitExt'(unit_code);
  assign frame    = {id_ext[ID_BITS-1:0], 1'b0, switch_on, unit_ext[UNIT_BITS-1:0]};
  assign is_start = (req_type == REQ_START);

  orst_queue #(.W(FW + 1)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({is_start, frame}),
    .full  (full),
    .pop   (cmd_pop),
    .dout  ({cmd_start, cmd_frame}),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
endmodule

[rtl/orst_back.sv]
module orst_back #(
  parameter int FW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  orst_pkg::cfg_t       cfg,
  input  logic                 cmd_valid,
  input  logic                 cmd_start,
  input  logic [FW-1:0]        cmd_frame,
  input  logic                 out_full,
  output orst_pkg::res_t       res,
  output orst_pkg::back_stat_t stat
);
  import orst_pkg::*;

  localparam int BW = $clog2(FW + 1);
  localparam int SW = $clog2(FW);

  phase_t            phase, a_phase, ld_phase, phase_next;
  logic [TICK_W-1:0] cnt, a_cnt, cnt_next;
  logic [BW-1:0]     bit_idx, a_bit, bit_next;
  logic              pip, a_pip, pip_next;
  logic [REP_W-1:0]  fl, a_fl, fl_next, fl_dec;
  logic              level, a_level, level_next;
  logic [FW-1:0]     frame, frame_next;
  logic              pending, take, step, do_load, done, pulse, res_pending;
  logic [BW-1:0]     sh_full;
  seg_t              seg;

  function automatic seg_t seg_load(input phase_t ph, input logic one, input cfg_t c);
    seg_t s;
    unique case (ph) inside
      PH_SYNC1, PH_SYNC2, PH_CLOSE: s = '{level: 1'b1, ticks: c.sync_high};
      PH_LATCH1: s = '{level: 1'b0, ticks: c.first_latch};
      PH_LATCH2: s = '{level: 1'b0, ticks: c.second_latch};
      PH_DHI:    s = '{level: 1'b1, ticks: c.pulse_high};
      PH_DLO:    s = '{level: 1'b0, ticks: one ? c.long_low : c.short_low};
      PH_GAP:    s = '{level: 1'b0, ticks: c.gap};
      default:   s = '{level: 1'b0, ticks: '0};
    endcase
    return s;
  endfunction

  // a segment that ran out still needs its successor loaded
  assign pending = (phase != PH_IDLE) && (cnt == '0);

  // event: take one command from the queue
  always_comb begin
    a_phase    = phase;
    a_cnt      = cnt;
    a_bit      = bit_idx;
    a_pip      = pip;
    a_fl       = fl;
    a_level    = level;
    frame_next = frame;
    take       = 1'b0;
    if (!pending && cmd_valid) begin
      take = 1'b1;
      if (cmd_start) begin
        if (phase == PH_IDLE) begin
          frame_next = cmd_frame;
          a_fl       = (cfg.repeat_count == '0) ? REP_W'(1) : cfg.repeat_count;
          a_bit      = '0;
          a_pip      = 1'b0;
          a_phase    = PH_SYNC1;
          a_level    = 1'b1;
          a_cnt      = cfg.sync_high;
        end
      end else if (phase != PH_IDLE) begin
        a_cnt = cnt - TICK_W'(1);
      end
    end
  end

  // current data pulse; a low half is only loaded right after its high half
  assign sh_full = BW'(FW - 1) - a_bit;
  assign pulse   = frame[sh_full[SW-1:0]] ^ a_pip;
  assign fl_dec  = (a_fl == '0) ? '0 : a_fl - REP_W'(1);

  // one segment advance per cycle in which the sequencer steps
  always_comb begin
    bit_next = a_bit;
    pip_next = a_pip;
    fl_next  = a_fl;
    ld_phase = a_phase;
    do_load  = 1'b0;
    done     = 1'b0;
    if (a_phase != PH_IDLE && a_cnt == '0) begin
      do_load = 1'b1;
      unique case (a_phase)
        PH_SYNC1:  ld_phase = PH_LATCH1;
        PH_LATCH1: ld_phase = PH_SYNC2;
        PH_SYNC2:  ld_phase = PH_LATCH2;
        PH_LATCH2: begin
          bit_next = '0;
          pip_next = 1'b0;
          ld_phase = PH_DHI;
        end
        PH_DHI:    ld_phase = PH_DLO;
        PH_DLO: begin
          if (!a_pip) begin
            pip_next = 1'b1;
            ld_phase = PH_DHI;
          end else begin
            pip_next = 1'b0;
            bit_next = a_bit + BW'(1);
            ld_phase = (a_bit == BW'(FW - 1)) ? PH_CLOSE : PH_DHI;
          end
        end
        PH_CLOSE:  ld_phase = PH_GAP;
        PH_GAP: begin
          fl_next  = fl_dec;
          bit_next = '0;
          pip_next = 1'b0;
          if (fl_dec == '0) begin
            ld_phase = PH_IDLE;
            done     = 1'b1;
          end else begin
            ld_phase = PH_SYNC1;
          end
        end
        default:   ld_phase = PH_IDLE;
      endcase
    end
  end

  assign seg = seg_load(ld_phase, pulse, cfg);

  always_comb begin
    phase_next = a_phase;
    level_next = a_level;
    cnt_next   = a_cnt;
    if (do_load) begin
      phase_next = ld_phase;
      level_next = seg.level;
      cnt_next   = seg.ticks;
    end
  end

  assign step        = !out_full && (pending || cmd_valid);
  assign res_pending = (phase_next != PH_IDLE) && (cnt_next == '0);

  assign stat.pop     = take && !out_full;
  assign stat.push    = step && !res_pending;
  assign stat.pending = pending;

  assign res.pin  = level_next;
  assign res.busy = (phase_next != PH_IDLE);
  assign res.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      cnt     <= '0;
      bit_idx <= '0;
      pip     <= 1'b0;
      fl      <= '0;
      level   <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      bit_idx <= bit_next;
      pip     <= pip_next;
      fl      <= fl_next;
      level   <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) frame <= frame_next;
  end
endmodule

[rtl/ook_remote_switch_transmitter.sv]
// OOK remote-switch transmitter. Every input beat is either a 1 us tick
// (req_type 0) or a start command (req_type 1) carrying sender id, unit code
// and on/off; every input beat yields exactly one result beat with the radio
// line level, a busy flag and a burst-done strobe. A start while idle loads a
// frame word (id, zero group bit, on/off, unit; MSB first) and sends
// repeat_count frames (one if repeat_count is zero) of sync/latch/sync/latch,
// one Manchester pulse pair per bit, a closing pulse and a low gap; a start
// while busy and a tick while idle change nothing. Timing registers sit on the
// APB port at byte address 4*index; the user must see that they are written
// only while the block is idle, as the block does not enforce it. The front
// queue feeds the sequencer, which handles one beat and one segment change per
// cycle and drops the result into a two-entry output queue, so push and pop
// sustain one beat per clock when empty is low and pop is high. Each segment
// programmed to zero ticks is skipped in a sequencer step of its own that
// takes no beat, during which the front queue holds further beats (full may
// rise); only a zero-length first sync pulse right at a start is skipped for
// free. With nothing stalled, a result passes both registered queues.
`include "ook_remote_switch_transmitter_assert.svh"

module ook_remote_switch_transmitter #(
  parameter int ID_BITS   = 26,
  parameter int UNIT_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // input beats
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type,
  input  logic [orst_pkg::SENDER_W-1:0] sender_id,
  input  logic [orst_pkg::UNIT_W-1:0]   unit_code,
  input  logic                          switch_on,
  // result beats
  output logic                          empty,
  input  logic                          pop,
  output logic                          pin_level,
  output logic                          busy_res,
  output logic                          burst_done,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [orst_pkg::ADDR_W-1:0]   paddr,
  input  logic [orst_pkg::DATA_W-1:0]   pwdata,
  output logic [orst_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import orst_pkg::*;

  // frame word: id bits, group bit, on/off bit, unit bits
  localparam int FW = ID_BITS + 2 + UNIT_BITS;

  cfg_t          cfg;
  logic          cmd_valid;
  logic          cmd_start;
  logic [FW-1:0] cmd_frame;
  logic          out_full;
  res_t          res;
  res_t          res_head;
  back_stat_t    stat;

  orst_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: packs the frame word, queues tick/start beats
  orst_front #(
    .ID_BITS   (ID_BITS),
    .UNIT_BITS (UNIT_BITS),
    .FW        (FW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .sender_id (sender_id),
    .unit_code (unit_code),
    .switch_on (switch_on),
    .cmd_valid (cmd_valid),
    .cmd_start (cmd_start),
    .cmd_frame (cmd_frame),
    .cmd_pop   (stat.pop)
  );

  // back: segment sequencer and tick counter
  orst_back #(.FW(FW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_start (cmd_start),
    .cmd_frame (cmd_frame),
    .out_full  (out_full),
    .res       (res),
    .stat      (stat)
  );

  // result queue decouples the sequencer from the consumer
  orst_queue #(.W($bits(res_t))) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (stat.push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign pin_level  = res_head.pin;
  assign busy_res   = res_head.busy;
  assign burst_done = res_head.done;

  // sequencer never writes a result into a full queue
  `ORST_ASSERT_NOW(a_no_push_full, stat.push, !out_full)
  // a command is only taken once any expired segment has been reloaded
  `ORST_ASSERT_NOW(a_pop_settled, stat.pop, !stat.pending)
  // burst end leaves the line idle and low
  `ORST_ASSERT_NOW(a_done_idle, stat.push && res.done, !res.busy && !res.pin)
  // a pending segment is resolved before the next command is popped
  `ORST_ASSERT_NEXT(a_pending_stall, stat.pending && out_full, !stat.pop)
endmodule

[bench/tb_ook_remote_switch_transmitter.sv]
`timescale 1ns / 1ps

// Bench for the OOK remote-switch transmitter.
// Every input beat (tick or start) yields one result beat; a cycle-free model
// of the segment sequencer predicts pin level, busy and burst-done per beat.
module tb_ook_remote_switch_transmitter;
  import orst_pkg::*;

  localparam logic REQ_TICK    = ~REQ_START;
  localparam int   QUIET_LIMIT = 20000;  // cycles with no beat moving
  localparam int   TAIL_CYCLES = 20;     // settle time after the last result

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                push      = 1'b0;
  logic                full;
  logic                req_type  = 1'b0;
  logic [SENDER_W-1:0] sender_id = '0;
  logic [UNIT_W-1:0]   unit_code = '0;
  logic                switch_on = 1'b0;
  logic                empty;
  logic                pop       = 1'b0;
  logic                pin_level;
  logic                busy_res;
  logic                burst_done;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ook_remote_switch_transmitter i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .sender_id  (sender_id),
    .unit_code  (unit_code),
    .switch_on  (switch_on),
    .empty      (empty),
    .pop        (pop),
    .pin_level  (pin_level),
    .busy_res   (busy_res),
    .burst_done (burst_done),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Waveform predictor: own copy of the timing registers and sequencer state.
  // ---------------------------------------------------------------------------
  // indexed by reg_idx_t; the repeat entry only keeps its low 4 bits
  logic [15:0] tick_cfg [8] = '{16'd310, 16'd1340, 16'd310, 16'd275,
                                16'd9900, 16'd2675, 16'd5, 16'd10000};

  phase_t      seg_phase   = PH_IDLE;
  logic [15:0] seg_left    = '0;   // ticks left in the current segment
  logic [31:0] frame_word  = '0;   // id, group (0), on/off, unit; MSB first
  logic [5:0]  bit_pos     = '0;
  logic        second_half = 1'b0; // second pulse of the Manchester pair
  logic [3:0]  frames_left = '0;
  logic        line_hi     = 1'b0;
  logic        burst_end   = 1'b0;

  res_t pending_levels [$];        // expected result beats, oldest first

  int beats_sent, live_beats, bursts_started, bursts_ended;
  int reg_writes, results_checked, fail_count;
  int quiet_cycles;
  bit idle_on = 1'b1;

  function automatic void enter_segment(phase_t ph);
    seg_phase = ph;
    case (ph)
      PH_SYNC1, PH_SYNC2, PH_CLOSE: begin
        line_hi  = 1'b1;
        seg_left = tick_cfg[REG_SYNC_HIGH];
      end
      PH_LATCH1: begin
        line_hi  = 1'b0;
        seg_left = tick_cfg[REG_FIRST_LATCH];
      end
      PH_LATCH2: begin
        line_hi  = 1'b0;
        seg_left = tick_cfg[REG_SECOND_LATCH];
      end
      PH_DHI: begin
        line_hi  = 1'b1;
        seg_left = tick_cfg[REG_PULSE_HIGH];
      end
      PH_DLO: begin
        // second pulse of a pair carries the inverted bit
        line_hi  = 1'b0;
        seg_left = (frame_word[31 - int'(bit_pos)] ^ second_half) ?
                   tick_cfg[REG_LONG_LOW] : tick_cfg[REG_SHORT_LOW];
      end
      PH_GAP: begin
        line_hi  = 1'b0;
        seg_left = tick_cfg[REG_GAP];
      end
      default: begin
        seg_phase = PH_IDLE;
        line_hi   = 1'b0;
        seg_left  = '0;
      end
    endcase
  endfunction

  function automatic void next_segment();
    case (seg_phase)
      PH_SYNC1:  enter_segment(PH_LATCH1);
      PH_LATCH1: enter_segment(PH_SYNC2);
      PH_SYNC2:  enter_segment(PH_LATCH2);
      PH_LATCH2: begin
        bit_pos     = '0;
        second_half = 1'b0;
        enter_segment(PH_DHI);
      end
      PH_DHI:    enter_segment(PH_DLO);
      PH_DLO: begin
        if (!second_half) begin
          second_half = 1'b1;
          enter_segment(PH_DHI);
        end else begin
          second_half = 1'b0;
          bit_pos     = bit_pos + 6'd1;
          if (bit_pos >= 6'd32) enter_segment(PH_CLOSE);
          else enter_segment(PH_DHI);
        end
      end
      PH_CLOSE:  enter_segment(PH_GAP);
      PH_GAP: begin
        if (frames_left != 0) frames_left = frames_left - 4'd1;
        bit_pos     = '0;
        second_half = 1'b0;
        if (frames_left == 0) begin
          enter_segment(PH_IDLE);
          burst_end = 1'b1;
        end else begin
          enter_segment(PH_SYNC1);
        end
      end
      default:   enter_segment(PH_IDLE);
    endcase
  endfunction

  // Result of one accepted beat; zero-length segments fall through at once.
  function automatic res_t predict_line(logic kind, logic [SENDER_W-1:0] id,
                                        logic [UNIT_W-1:0] unit, logic on);
    res_t r;
    burst_end = 1'b0;
    if (kind == REQ_START) begin
      if (seg_phase == PH_IDLE) begin
        frame_word  = {id, 1'b0, on, unit};
        frames_left = (tick_cfg[REG_REPEAT][3:0] != 0) ? tick_cfg[REG_REPEAT][3:0] : 4'd1;
        bit_pos     = '0;
        second_half = 1'b0;
        enter_segment(PH_SYNC1);
        while (seg_phase != PH_IDLE && seg_left == 0) next_segment();
        live_beats++;
        bursts_started++;
      end
    end else if (seg_phase != PH_IDLE) begin
      seg_left = seg_left - 16'd1;
      while (seg_phase != PH_IDLE && seg_left == 0) next_segment();
      live_beats++;
    end
    if (burst_end) bursts_ended++;
    r.pin  = line_hi;
    r.busy = (seg_phase != PH_IDLE);
    r.done = burst_end;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, compare at the rising edge.
  // ---------------------------------------------------------------------------
  int rx_stall = 0;

  always @(negedge clk) begin
    if (rx_stall > 0) rx_stall--;
    else if (idle_on && $urandom_range(0, 9) == 0) rx_stall = $urandom_range(1, 13);
    pop <= (rx_stall == 0);
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_levels.size() == 0) begin
        $error("result beat with nothing expected: pin %0b busy %0b done %0b",
               pin_level, busy_res, burst_done);
        fail_count++;
      end else begin
        want = pending_levels.pop_front();
        results_checked++;
        if (pin_level !== want.pin) begin
          $error("pin_level: expected %0b, got %0b", want.pin, pin_level);
          fail_count++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, busy_res);
          fail_count++;
        end
        if (burst_done !== want.done) begin
          $error("burst_done: expected %0b, got %0b", want.done, burst_done);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: nothing moving on either side for too long ends the run.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // One beat; optional idle burst first, then hold until accepted.
  task automatic send_beat(logic kind, logic [SENDER_W-1:0] id,
                           logic [UNIT_W-1:0] unit, logic on);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push      <= 1'b1;
    req_type  <= kind;
    sender_id <= id;
    unit_code <= unit;
    switch_on <= on;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    pending_levels.push_back(predict_line(kind, id, unit, on));
  endtask

  // tick beats carry random payload, which the block must ignore
  task automatic send_tick();
    send_beat(REQ_TICK, SENDER_W'($urandom), UNIT_W'($urandom), 1'($urandom));
  endtask

  task automatic send_random_start();
    send_beat(REQ_START, SENDER_W'($urandom), UNIT_W'($urandom), 1'($urandom));
  endtask

  // Tick until the burst is over; some starts land mid-burst and are dropped.
  task automatic run_to_idle(int busy_start_pct);
    while (seg_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < busy_start_pct) send_random_start();
      else send_tick();
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(logic wr, reg_idx_t idx, logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_check(reg_idx_t idx);
    logic [DATA_W-1:0] back;
    apb_xfer(1'b0, idx, DATA_W'($urandom), back);
    if (back !== {16'h0, tick_cfg[idx]}) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), tick_cfg[idx], back);
      fail_count++;
    end
  endtask

  // Unused upper data bits are randomized; the register keeps its own width.
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] back;
    word       = $urandom;
    word[15:0] = value;
    if (idx == REG_REPEAT) word[15:4] = 12'($urandom);
    apb_xfer(1'b1, idx, word, back);
    tick_cfg[idx] = (idx == REG_REPEAT) ? {12'h0, word[3:0]} : word[15:0];
    reg_writes++;
    read_check(idx);
  endtask

  // Only legal between bursts: wait out the results first.
  task automatic set_timing(logic [15:0] pulse_hi, logic [15:0] long_lo,
                            logic [15:0] short_lo, logic [15:0] sync_hi,
                            logic [15:0] latch1, logic [15:0] latch2,
                            logic [15:0] reps, logic [15:0] gap);
    drain_results();
    write_reg(REG_PULSE_HIGH, pulse_hi);
    write_reg(REG_LONG_LOW, long_lo);
    write_reg(REG_SHORT_LOW, short_lo);
    write_reg(REG_SYNC_HIGH, sync_hi);
    write_reg(REG_FIRST_LATCH, latch1);
    write_reg(REG_SECOND_LATCH, latch2);
    write_reg(REG_REPEAT, reps);
    write_reg(REG_GAP, gap);
  endtask

  // Random durations stay short so a burst costs a few hundred beats.
  function automatic logic [15:0] pick_pulse();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return 16'd0;
    if (r < 16) return 16'd1;
    if (r < 19) return 16'd2;
    return 16'd3;
  endfunction

  function automatic logic [15:0] pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'd0;
    if (r < 7) return 16'($urandom_range(1, 4));
    if (r < 9) return 16'($urandom_range(5, 30));
    return 16'($urandom_range(31, 200));
  endfunction

  function automatic logic [15:0] pick_repeat();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r < 8) return 16'($urandom_range(1, 3));
    if (r == 8) return 16'($urandom_range(4, 8));
    return 16'($urandom_range(9, 15));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    for (int i = 0; i < 8; i++) read_check(reg_idx_t'(i));
  endtask

  // line must stay low with no busy flag
  task automatic test_idle_ticks();
    send_beat(REQ_TICK, '1, '1, 1'b1);
    send_beat(REQ_TICK, '0, '0, 1'b0);
    send_tick();
  endtask

  task automatic test_directed_frames();
    set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd1);
    send_beat(REQ_START, '1, '1, 1'b1);
    repeat (3) send_tick();
    send_beat(REQ_START, '0, '0, 1'b0);  // dropped, burst in flight
    run_to_idle(0);
    send_beat(REQ_START, '0, '0, 1'b0);  // start on the beat after done
    run_to_idle(0);
    send_beat(REQ_START, 26'h2AAAAAA, 4'h5, 1'b1);
    run_to_idle(2);
    // long and short lows differ so pair order shows on the line
    set_timing(16'd1, 16'd3, 16'd2, 16'd2, 16'd3, 16'd2, 16'd1, 16'd2);
    send_beat(REQ_START, 26'h1555555, 4'hA, 1'b0);
    run_to_idle(0);
  endtask

  task automatic test_zero_segments();
    // zero-length segments are skipped inside the same beat
    set_timing(16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    send_random_start();
    run_to_idle(0);
    // everything zero: whole burst finishes in the start beat
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_random_start();
    repeat (2) send_tick();
    // maximum repeat count, only the gap takes time
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd15, 16'd1);
    send_random_start();
    run_to_idle(0);
    // repeat count zero sends one frame
    set_timing(16'd1, 16'd0, 16'd1, 16'd0, 16'd2, 16'd0, 16'd0, 16'd3);
    send_random_start();
    run_to_idle(3);
  endtask

  // Segment count past eight bits; no idling here to keep the run short.
  task automatic test_long_segments();
    idle_on = 1'b0;
    set_timing(16'd0, 16'd1, 16'd0, 16'd0, 16'd300, 16'd0, 16'd1, 16'd0);
    send_random_start();
    run_to_idle(0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(int target, bit with_idle);
    int first;
    first   = live_beats;
    idle_on = with_idle;
    while (live_beats - first < target) begin
      set_timing(pick_pulse(), pick_pulse(), pick_pulse(), pick_span(),
                 pick_span(), pick_span(), pick_repeat(), pick_span());
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3)) send_tick();
        send_random_start();
        run_to_idle(3);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_idle_ticks();
    test_directed_frames();
    test_zero_segments();
    test_long_segments();
    test_random_traffic(500, 1'b1);
    test_random_traffic(150, 1'b0);  // closing stretch without any idling

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_levels.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_levels.size());
      fail_count++;
    end

    $display("sent %0d beats (%0d advanced the waveform), %0d bursts started, %0d ended",
             beats_sent, live_beats, bursts_started, bursts_ended);
    $display("%0d register writes with readback, %0d result beats compared",
             reg_writes, results_checked);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/orst_pkg.sv
rtl/orst_queue.sv
rtl/orst_regs.sv
rtl/orst_front.sv
rtl/orst_back.sv
rtl/ook_remote_switch_transmitter.sv
bench/tb_ook_remote_switch_transmitter.sv
